// ===== src/dtls_retransmit_backoff_timer_top_assert.svh =====
// Assertion macros used by the timer core.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DTLS_RETRANSMIT_BACKOFF_TIMER_TOP_ASSERT_SVH
`define DTLS_RETRANSMIT_BACKOFF_TIMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define DTLSRB_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`define DTLSRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DTLSRB_ASSERT_ALWAYS(lbl, expr, msg)

`define DTLSRB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/dtlsrb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtlsrb_pkg;

    // Field widths.
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned SEC_W      = 32;
    localparam int unsigned USEC_W     = 20;
    localparam int unsigned MTU_W      = 16;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned DUR_W      = 6;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Stream widths, rounded up to whole bytes.
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 88;

    // Timing constants.
    localparam logic [DUR_W-1:0]  DURATION_CAP  = 6'd60;
    localparam logic [USEC_W-1:0] MIN_LEFT_USEC = 20'd15000;
    localparam logic [USEC_W:0]   USEC_PER_SEC  = 21'd1000000;
    localparam logic [USEC_W-1:0] MAX_USEC      = 20'd999999;
    localparam logic [CNT_W-1:0]  MTU_ALERT_THRESHOLD = 8'd2;
    localparam logic [CNT_W-1:0]  CNT_MAX       = 8'hFF;

    // Register reset values.
    localparam logic [CNT_W-1:0] ALERT_LIMIT_RST        = 8'd12;
    localparam logic [CNT_W-1:0] READ_TIMEOUT_LIMIT_RST = 8'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_STOP   = 2'd1,
        CMD_HANDLE = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE       = 2'd0,
        ST_RETRANSMIT = 2'd1,
        ST_FAILED     = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALERT_LIMIT        = 2'd0,
        REG_READ_TIMEOUT_LIMIT = 2'd1,
        REG_NO_MTU_QUERY       = 2'd2,
        REG_CONFIGURED_MTU     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [MTU_W-1:0]  fallback_mtu;
        logic [USEC_W-1:0] now_usec;
        logic [SEC_W-1:0]  now_sec;
        t_cmd              cmd;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0]  rto_count;
        logic [MTU_W-1:0]  path_mtu;
        logic [DUR_W-1:0]  backoff_seconds;
        logic [USEC_W-1:0] remaining_usec;
        logic [SEC_W-1:0]  remaining_sec;
        logic              timer_running;
        t_status           status;
    } t_result;

endpackage

`default_nettype wire

// ===== src/dtlsrb_time_left.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Time from now to an armed deadline, forced to zero when the deadline
// is idle, already passed, or less than the minimum interval away.
module dtlsrb_time_left (
    input  wire logic [dtlsrb_pkg::SEC_W-1:0]  i_deadline_sec,
    input  wire logic [dtlsrb_pkg::USEC_W-1:0] i_deadline_usec,
    input  wire logic [dtlsrb_pkg::SEC_W-1:0]  i_now_sec,
    input  wire logic [dtlsrb_pkg::USEC_W-1:0] i_now_usec,
    output logic      [dtlsrb_pkg::SEC_W-1:0]  o_left_sec,
    output logic      [dtlsrb_pkg::USEC_W-1:0] o_left_usec,
    output logic                               o_expired
);
    import dtlsrb_pkg::*;

    logic              armed;
    logic              usec_borrow;
    logic [USEC_W:0]   usec_diff;
    logic [SEC_W:0]    sec_diff;
    logic              too_close;

    assign armed       = (|i_deadline_sec) || (|i_deadline_usec);
    assign usec_borrow = i_deadline_usec < i_now_usec;

    // Microsecond part with a borrow from the seconds when needed.
    assign usec_diff = {1'b0, i_deadline_usec} - {1'b0, i_now_usec}
                     + (usec_borrow ? USEC_PER_SEC : '0);

    // A negative seconds difference means the deadline lies in the past.
    assign sec_diff = {1'b0, i_deadline_sec} - {1'b0, i_now_sec}
                    - {{SEC_W{1'b0}}, usec_borrow};

    assign too_close = (sec_diff[SEC_W-1:0] == '0) && (usec_diff[USEC_W-1:0] < MIN_LEFT_USEC);
    assign o_expired = !armed || sec_diff[SEC_W] || too_close;

    assign o_left_sec  = o_expired ? '0 : sec_diff[SEC_W-1:0];
    assign o_left_usec = o_expired ? '0 : usec_diff[USEC_W-1:0];

endmodule

`default_nettype wire

// ===== src/dtlsrb_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "dtls_retransmit_backoff_timer_top_assert.svh"

// Timer state, configuration registers and the per-transaction update.
module dtlsrb_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_adv,
    input  wire dtlsrb_pkg::t_item                   i_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [dtlsrb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dtlsrb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output dtlsrb_pkg::t_result                      o_result
);
    import dtlsrb_pkg::*;

    // Configuration registers.
    logic [CNT_W-1:0] r_alert_limit;
    logic [CNT_W-1:0] r_rto_limit;
    logic             r_no_mtu_query;

    // Timer state.
    logic [SEC_W-1:0]  r_dl_sec,    n_dl_sec;
    logic [USEC_W-1:0] r_dl_usec,   n_dl_usec;
    logic [DUR_W-1:0]  r_dur,       n_dur;
    logic [CNT_W-1:0]  r_alert_cnt, n_alert_cnt;
    logic [CNT_W-1:0]  r_rto_cnt,   n_rto_cnt;
    logic [MTU_W-1:0]  r_mtu,       n_mtu;

    logic [USEC_W-1:0] now_usec;
    logic              armed;
    logic [SEC_W-1:0]  pre_sec;
    logic [USEC_W-1:0] pre_usec;
    logic              pre_expired;
    logic [DUR_W:0]    dur_dbl;
    logic [DUR_W-1:0]  dur_next;
    logic [DUR_W-1:0]  dur_start;
    logic [SEC_W:0]    sum_start;
    logic [SEC_W:0]    sum_backoff;
    logic [SEC_W:0]    sum_one;
    logic              backoff_armed;
    logic [CNT_W-1:0]  alert_inc;
    logic [CNT_W-1:0]  rto_inc;
    logic              fail;
    logic              mtu_lower;
    logic              rearmed;
    logic              arm_carry;
    t_status           status;
    logic              running;

    // Clamp microseconds to the last valid value of a second.
    assign now_usec = (i_item.now_usec > MAX_USEC) ? MAX_USEC : i_item.now_usec;
    assign armed    = (|r_dl_sec) || (|r_dl_usec);

    // Time left on the current deadline.
    dtlsrb_time_left u_pre_left (
        .i_deadline_sec  (r_dl_sec),
        .i_deadline_usec (r_dl_usec),
        .i_now_sec       (i_item.now_sec),
        .i_now_usec      (now_usec),
        .o_left_sec      (pre_sec),
        .o_left_usec     (pre_usec),
        .o_expired       (pre_expired)
    );

    // Doubled duration with cap, and the candidate deadlines.
    assign dur_dbl   = {r_dur, 1'b0};
    assign dur_next  = (dur_dbl > {1'b0, DURATION_CAP}) ? DURATION_CAP : dur_dbl[DUR_W-1:0];
    assign dur_start = armed ? r_dur : DUR_W'(1);
    assign sum_start   = {1'b0, i_item.now_sec} + {{(SEC_W-DUR_W+1){1'b0}}, dur_start};
    assign sum_backoff = {1'b0, i_item.now_sec} + {{(SEC_W-DUR_W+1){1'b0}}, dur_next};
    assign sum_one     = {1'b0, i_item.now_sec} + (SEC_W+1)'(1);
    assign backoff_armed = (|sum_backoff[SEC_W-1:0]) || (|now_usec);

    // Saturating counters and the decisions that depend on them.
    assign alert_inc = (r_alert_cnt == CNT_MAX) ? r_alert_cnt : r_alert_cnt + CNT_W'(1);
    assign rto_inc   = (r_rto_cnt == CNT_MAX) ? r_rto_cnt : r_rto_cnt + CNT_W'(1);
    assign fail      = alert_inc > r_alert_limit;
    assign mtu_lower = (alert_inc > MTU_ALERT_THRESHOLD) && !r_no_mtu_query &&
                       (i_item.fallback_mtu < r_mtu);

    // Next state for one transaction.
    always_comb begin
        n_dl_sec    = r_dl_sec;
        n_dl_usec   = r_dl_usec;
        n_dur       = r_dur;
        n_alert_cnt = r_alert_cnt;
        n_rto_cnt   = r_rto_cnt;
        n_mtu       = r_mtu;
        status      = ST_NONE;
        rearmed     = 1'b0;
        arm_carry   = 1'b0;
        case (i_item.cmd)
            CMD_START: begin
                rearmed   = 1'b1;
                n_dur     = dur_start;
                n_dl_sec  = sum_start[SEC_W-1:0];
                n_dl_usec = now_usec;
                arm_carry = sum_start[SEC_W];
            end
            CMD_STOP: begin
                n_dl_sec    = '0;
                n_dl_usec   = '0;
                n_dur       = DUR_W'(1);
                n_alert_cnt = '0;
                n_rto_cnt   = '0;
            end
            CMD_HANDLE: begin
                if (armed && pre_expired) begin
                    rearmed     = 1'b1;
                    n_alert_cnt = alert_inc;
                    n_dl_usec   = now_usec;
                    if (mtu_lower) begin
                        n_mtu = i_item.fallback_mtu;
                    end
                    if (fail || backoff_armed) begin
                        n_dur     = dur_next;
                        n_dl_sec  = sum_backoff[SEC_W-1:0];
                        arm_carry = sum_backoff[SEC_W];
                    end else begin
                        // The backed-off deadline wrapped to idle, so rearming restarts at 1 s.
                        n_dur     = DUR_W'(1);
                        n_dl_sec  = sum_one[SEC_W-1:0];
                        arm_carry = sum_one[SEC_W];
                    end
                    if (fail) begin
                        status = ST_FAILED;
                    end else begin
                        status    = ST_RETRANSMIT;
                        n_rto_cnt = (rto_inc > r_rto_limit) ? CNT_W'(1) : rto_inc;
                    end
                end
            end
            CMD_QUERY: begin
                status = ST_NONE;
            end
            default: begin
                status = ST_NONE;
            end
        endcase
    end

    assign running = (|n_dl_sec) || (|n_dl_usec);

    // Result fields, taken from the state after this transaction.
    always_comb begin
        o_result.status          = status;
        o_result.timer_running   = running;
        o_result.backoff_seconds = n_dur;
        o_result.path_mtu        = n_mtu;
        o_result.rto_count       = n_rto_cnt;
        if (i_item.cmd == CMD_STOP) begin
            o_result.remaining_sec  = '0;
            o_result.remaining_usec = '0;
        end else if (rearmed) begin
            // A fresh deadline lies exactly the duration ahead unless the seconds wrapped.
            o_result.remaining_sec  = (arm_carry || !running) ? '0
                                    : {{(SEC_W-DUR_W){1'b0}}, n_dur};
            o_result.remaining_usec = '0;
        end else begin
            o_result.remaining_sec  = pre_sec;
            o_result.remaining_usec = pre_usec;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alert_limit  <= ALERT_LIMIT_RST;
            r_rto_limit    <= READ_TIMEOUT_LIMIT_RST;
            r_no_mtu_query <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ALERT_LIMIT:        r_alert_limit  <= i_cfg_data[CNT_W-1:0];
                REG_READ_TIMEOUT_LIMIT: r_rto_limit    <= i_cfg_data[CNT_W-1:0];
                REG_NO_MTU_QUERY:       r_no_mtu_query <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Timer state registers; a write of the configured MTU also loads the current MTU.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_sec    <= '0;
            r_dl_usec   <= '0;
            r_dur       <= DUR_W'(1);
            r_alert_cnt <= '0;
            r_rto_cnt   <= '0;
            r_mtu       <= '0;
        end else begin
            if (i_adv) begin
                r_dl_sec    <= n_dl_sec;
                r_dl_usec   <= n_dl_usec;
                r_dur       <= n_dur;
                r_alert_cnt <= n_alert_cnt;
                r_rto_cnt   <= n_rto_cnt;
            end
            if (i_cfg_we && (t_reg_idx'(i_cfg_index) == REG_CONFIGURED_MTU)) begin
                r_mtu <= i_cfg_data[MTU_W-1:0];
            end else if (i_adv) begin
                r_mtu <= n_mtu;
            end
        end
    end

    // Conditions checked by the assertions below.
    logic dur_ok;
    logic adv_stop;
    logic adv_keep;
    logic timer_clear;
    assign dur_ok      = (r_dur >= DUR_W'(1)) && (r_dur <= DURATION_CAP);
    assign adv_stop    = i_adv && (i_item.cmd == CMD_STOP);
    assign adv_keep    = i_adv && (i_item.cmd != CMD_STOP);
    assign timer_clear = !armed && (r_alert_cnt == '0) && (r_rto_cnt == '0);

    `DTLSRB_ASSERT_ALWAYS(a_dur_range, dur_ok, "backoff duration out of range")
    `DTLSRB_ASSERT_NEXT(a_stop_clears, adv_stop, timer_clear, "stop did not clear the timer")
    `DTLSRB_ASSERT_NEXT(a_alert_up, adv_keep, r_alert_cnt >= $past(r_alert_cnt), "alerts fell")

endmodule

`default_nettype wire

// ===== src/dtls_retransmit_backoff_timer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle unless the result stream stalls; the input and
// result registers let a new item enter while a finished result still waits downstream.
// Reset: synchronous, active low; timer idle, duration 1 s, counters and MTU zero,
// alert limit 12, read timeout limit 2, MTU lowering enabled.
module dtls_retransmit_backoff_timer_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Input stream.
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // tdata: now_sec[31:0], now_usec[51:32], fallback_mtu[67:52], zero fill above.
    input  wire logic [dtlsrb_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: cmd[1:0].
    input  wire logic [dtlsrb_pkg::CMD_W-1:0]          i_s_axis_tuser,
    // Result stream.
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // tdata: timer_running[0], remaining_sec[32:1], remaining_usec[52:33],
    // backoff_seconds[58:53], path_mtu[74:59], rto_count[82:75], zero fill above.
    output logic      [dtlsrb_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // tuser: status[1:0].
    output logic      [dtlsrb_pkg::STATUS_W-1:0]       o_m_axis_tuser,
    // Configuration write port.
    input  wire logic                                  i_cfg_we,
    input  wire logic [dtlsrb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [dtlsrb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dtlsrb_pkg::*;

    localparam int unsigned IN_USED_W  = SEC_W + USEC_W + MTU_W;
    localparam int unsigned OUT_USED_W = 1 + SEC_W + USEC_W + DUR_W + MTU_W + CNT_W;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result result;
    logic    adv;

    // The item in the input register moves on when the result register is free or drains.
    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.cmd          <= t_cmd'(i_s_axis_tuser);
            r_item.now_sec      <= i_s_axis_tdata[SEC_W-1:0];
            r_item.now_usec     <= i_s_axis_tdata[SEC_W +: USEC_W];
            r_item.fallback_mtu <= i_s_axis_tdata[SEC_W+USEC_W +: MTU_W];
        end
    end

    dtlsrb_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (r_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_result <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_result.status;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                              r_result.rto_count,
                              r_result.path_mtu,
                              r_result.backoff_seconds,
                              r_result.remaining_usec,
                              r_result.remaining_sec,
                              r_result.timer_running};

    // Zero fill of the input bus carries no information.
    logic unused_in_fill;
    assign unused_in_fill = ^i_s_axis_tdata[IN_TDATA_W-1:IN_USED_W];

endmodule

`default_nettype wire
